/* design/cmm_pkg.sv */
// package for the console cpu memory map
// holds the beat structs, command and state enums and sizing constants
// no dependencies
package cmm_pkg;

  localparam int unsigned RamBytes   = 2048;
  localparam int unsigned RamAw      = $clog2(RamBytes);
  localparam int unsigned VideoCount = 8;
  localparam int unsigned RegCount   = 32;
  localparam int unsigned CartCount  = 49120;
  localparam int unsigned MemDepth   = RamBytes + VideoCount + RegCount + CartCount;
  localparam int unsigned IdxW       = $clog2(MemDepth);

  localparam logic [15:0] VideoBase = 16'h2000;
  localparam logic [15:0] AudioBase = 16'h4000;
  localparam logic [15:0] CartBase  = 16'h4020;

  typedef enum logic [2:0] {
    CmdRdByte   = 3'd0,
    CmdWrByte   = 3'd1,
    CmdRdWord   = 3'd2,
    CmdWrWord   = 3'd3,
    CmdPushByte = 3'd4,
    CmdPullByte = 3'd5,
    CmdPushWord = 3'd6,
    CmdPullWord = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StAcc0,
    StAcc1,
    StDone
  } state_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] address;
    logic [15:0] write_data;
    logic [7:0]  stack_pointer;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [7:0]  stack_pointer_out;
  } out_beat_t;

endpackage

/* design/console_cpu_memory_map.sv */
// console cpu memory map: one byte memory holds ram, video, audio, spare and cartridge bytes
// when enabled a beat passes accept (StIdle), two memory slots (StAcc0, StAcc1) and result (StDone);
// when disabled it goes from accept straight to result; no new beat is taken until the result is loaded
// the single-port memory serializes the two byte accesses of a word
// reset: after rst_ni rises a clearing pass zeroes all MemDepth (51208) bytes of the memory;
// no input beat is taken until it ends, config writes are taken at any time
// depends on cmm_pkg
module console_cpu_memory_map (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  cmm_pkg::in_beat_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cmm_pkg::out_beat_t   out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_data_i
);

  localparam int unsigned IdxW = cmm_pkg::IdxW;

  function automatic logic [IdxW-1:0] bus_idx(input logic [15:0] a);
    logic [IdxW-1:0] idx;
    if (a < cmm_pkg::VideoBase) begin
      idx = IdxW'(a[cmm_pkg::RamAw-1:0]);
    end else if (a < cmm_pkg::AudioBase) begin
      idx = IdxW'(cmm_pkg::RamBytes) + IdxW'(a[2:0]);
    end else if (a < cmm_pkg::CartBase) begin
      idx = IdxW'(cmm_pkg::RamBytes + cmm_pkg::VideoCount) + IdxW'(a[4:0]);
    end else begin
      idx = IdxW'(a - cmm_pkg::CartBase)
          + IdxW'(cmm_pkg::RamBytes + cmm_pkg::VideoCount + cmm_pkg::RegCount);
    end
    return idx;
  endfunction

  function automatic logic [IdxW-1:0] stack_idx(input logic [7:0] s);
    logic [cmm_pkg::RamAw-1:0] r;
    r = cmm_pkg::RamAw'({1'b1, s});
    return IdxW'(r);
  endfunction

  cmm_pkg::state_e state_q, state_d;

  logic                  enable_q;
  logic [IdxW-1:0]       clr_q, clr_d;
  logic                  accept;

  logic [IdxW-1:0]       a0_q, a0_d, a1_q, a1_d;
  logic [7:0]            wb0_q, wb0_d, wb1_q, wb1_d;
  logic [7:0]            sp_q, sp_d;
  logic                  wr_q, wr_d, rd_q, rd_d, two_q, two_d, dis_q;
  logic [7:0]            lo_q;

  logic                  mem_we, mem_re;
  logic [IdxW-1:0]       mem_addr;
  logic [7:0]            mem_wdata;
  logic [7:0]            mem_q [cmm_pkg::MemDepth];
  logic [7:0]            rdata_q;

  logic                  out_valid_q, out_load;
  cmm_pkg::out_beat_t    out_q, out_d;

  cmm_pkg::cmd_e         cmd;
  logic [7:0]            sp_in;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != cmm_pkg::StIdle);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_load    = (state_q == cmm_pkg::StDone) && (!out_valid_q || !out_stall_i);

  // command decode at accept
  always_comb begin
    cmd   = cmm_pkg::cmd_e'(in_data_i.cmd);
    sp_in = in_data_i.stack_pointer;
    a0_d  = bus_idx(in_data_i.address);
    a1_d  = bus_idx(in_data_i.address + 16'd1);
    wb0_d = in_data_i.write_data[7:0];
    wb1_d = in_data_i.write_data[15:8];
    sp_d  = sp_in;
    wr_d  = 1'b0;
    rd_d  = 1'b0;
    two_d = 1'b0;
    unique case (cmd)
      cmm_pkg::CmdRdByte: begin
        rd_d = 1'b1;
      end
      cmm_pkg::CmdWrByte: begin
        wr_d = 1'b1;
      end
      cmm_pkg::CmdRdWord: begin
        rd_d  = 1'b1;
        two_d = 1'b1;
      end
      cmm_pkg::CmdWrWord: begin
        wr_d  = 1'b1;
        two_d = 1'b1;
      end
      cmm_pkg::CmdPushByte: begin
        wr_d = 1'b1;
        a0_d = stack_idx(sp_in);
        sp_d = sp_in - 8'd1;
      end
      cmm_pkg::CmdPullByte: begin
        rd_d = 1'b1;
        a0_d = stack_idx(sp_in + 8'd1);
        sp_d = sp_in + 8'd1;
      end
      cmm_pkg::CmdPushWord: begin
        wr_d  = 1'b1;
        two_d = 1'b1;
        a0_d  = stack_idx(sp_in);
        a1_d  = stack_idx(sp_in - 8'd1);
        wb0_d = in_data_i.write_data[15:8];
        wb1_d = in_data_i.write_data[7:0];
        sp_d  = sp_in - 8'd2;
      end
      cmm_pkg::CmdPullWord: begin
        rd_d  = 1'b1;
        two_d = 1'b1;
        a0_d  = stack_idx(sp_in + 8'd1);
        a1_d  = stack_idx(sp_in + 8'd2);
        sp_d  = sp_in + 8'd2;
      end
      default: begin
        rd_d = 1'b0;
      end
    endcase
    if (!enable_q) begin
      sp_d = sp_in;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cmm_pkg::StClear: begin
        if (clr_q == IdxW'(cmm_pkg::MemDepth - 1)) begin
          state_d = cmm_pkg::StIdle;
        end
      end
      cmm_pkg::StIdle: begin
        if (accept) begin
          state_d = enable_q ? cmm_pkg::StAcc0 : cmm_pkg::StDone;
        end
      end
      cmm_pkg::StAcc0: state_d = cmm_pkg::StAcc1;
      cmm_pkg::StAcc1: state_d = cmm_pkg::StDone;
      cmm_pkg::StDone: begin
        if (out_load) begin
          state_d = cmm_pkg::StIdle;
        end
      end
      default: state_d = cmm_pkg::StIdle;
    endcase
  end

  // memory port and result
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = a0_q;
    mem_wdata = wb0_q;
    clr_d     = clr_q;
    unique case (state_q)
      cmm_pkg::StClear: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = 8'h00;
        clr_d     = clr_q + IdxW'(1);
      end
      cmm_pkg::StAcc0: begin
        mem_we = wr_q;
        mem_re = rd_q;
      end
      cmm_pkg::StAcc1: begin
        mem_addr  = a1_q;
        mem_wdata = wb1_q;
        mem_we    = wr_q && two_q;
        mem_re    = rd_q && two_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase

    out_d.stack_pointer_out = sp_q;
    if (!rd_q) begin
      out_d.read_data = 16'h0000;
    end else if (dis_q) begin
      out_d.read_data = two_q ? 16'hFFFF : 16'h00FF;
    end else begin
      out_d.read_data = two_q ? {rdata_q, lo_q} : {8'h00, lo_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cmm_pkg::StClear;
      clr_q       <= '0;
      enable_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (cfg_valid_i && cfg_ready_o) begin
        enable_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a0_q  <= a0_d;
      a1_q  <= a1_d;
      wb0_q <= wb0_d;
      wb1_q <= wb1_d;
      sp_q  <= sp_d;
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      two_q <= two_d;
      dis_q <= !enable_q;
    end
    if (state_q == cmm_pkg::StAcc1) begin
      lo_q <= rdata_q;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == cmm_pkg::StAcc0 || state_q == cmm_pkg::StDone))
    else $error("accepted beat did not start a sequence");

  a_acc1_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cmm_pkg::StAcc1) |=> (state_q == cmm_pkg::StDone))
    else $error("second access not followed by result");

  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cmm_pkg::StIdle || state_q == cmm_pkg::StDone) |-> !mem_we)
    else $error("memory written outside an access slot");

  a_clr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cmm_pkg::StClear) |-> (clr_q < IdxW'(cmm_pkg::MemDepth)))
    else $error("clearing pass ran past the memory");
`endif

endmodule

/* verif/tb.sv */
// testbench for console_cpu_memory_map: directed and random bus, stack and enable traffic
// predicts each result beat from a shadow copy of the memory map and checks it in order
// depends on cmm_pkg and console_cpu_memory_map
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  cmm_pkg::in_beat_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  cmm_pkg::out_beat_t out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_data_i = 1'b0;

  cmm_pkg::in_beat_t  pending_items[$];
  cmm_pkg::out_beat_t expected_beats[$];
  cmm_pkg::out_beat_t want;
  logic [7:0] bus_bytes [0:65535];
  bit         bus_enabled = 1'b0;
  bit         no_idle = 1'b0;
  bit         hold_go = 1'b0;
  logic       hold_long = 1'b0;
  bit         taken;
  int         send_gap = 0;
  int         stall_left = 0;
  int         items_sent = 0;
  int         mismatches = 0;
  logic [7:0] stack_top = 8'hFF;
  int         stack_depth = 0;

  console_cpu_memory_map dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // byte cell behind a bus address, mirrors folded onto their base
  function automatic int home(logic [15:0] a);
    if (a < cmm_pkg::VideoBase) return int'(a % cmm_pkg::RamBytes);
    if (a < cmm_pkg::AudioBase) begin
      return int'(cmm_pkg::VideoBase) + int'(a % cmm_pkg::VideoCount);
    end
    return int'(a);
  endfunction

  function automatic cmm_pkg::out_beat_t bus_access(cmm_pkg::in_beat_t b);
    cmm_pkg::out_beat_t r;
    logic [7:0]  sp;
    logic [7:0]  lo;
    logic [15:0] rd;
    sp = b.stack_pointer;
    rd = '0;
    if (!bus_enabled) begin
      case (b.cmd)
        cmm_pkg::CmdRdByte, cmm_pkg::CmdPullByte: rd = 16'h00FF;
        cmm_pkg::CmdRdWord, cmm_pkg::CmdPullWord: rd = 16'hFFFF;
        default:                                  rd = '0;
      endcase
    end else begin
      case (b.cmd)
        cmm_pkg::CmdRdByte: rd = {8'h00, bus_bytes[home(b.address)]};
        cmm_pkg::CmdWrByte: bus_bytes[home(b.address)] = b.write_data[7:0];
        cmm_pkg::CmdRdWord: begin
          lo = bus_bytes[home(b.address)];
          rd = {bus_bytes[home(b.address + 16'd1)], lo};
        end
        cmm_pkg::CmdWrWord: begin
          bus_bytes[home(b.address)] = b.write_data[7:0];
          bus_bytes[home(b.address + 16'd1)] = b.write_data[15:8];
        end
        cmm_pkg::CmdPushByte: begin
          bus_bytes[home({8'h01, sp})] = b.write_data[7:0];
          sp = sp - 8'd1;
        end
        cmm_pkg::CmdPullByte: begin
          sp = sp + 8'd1;
          rd = {8'h00, bus_bytes[home({8'h01, sp})]};
        end
        cmm_pkg::CmdPushWord: begin
          bus_bytes[home({8'h01, sp})] = b.write_data[15:8];
          sp = sp - 8'd1;
          bus_bytes[home({8'h01, sp})] = b.write_data[7:0];
          sp = sp - 8'd1;
        end
        default: begin
          sp = sp + 8'd1;
          lo = bus_bytes[home({8'h01, sp})];
          sp = sp + 8'd1;
          rd = {bus_bytes[home({8'h01, sp})], lo};
        end
      endcase
    end
    r.read_data = rd;
    r.stack_pointer_out = sp;
    return r;
  endfunction

  function automatic logic [15:0] pick_address();
    logic [15:0] seams [6] = '{16'h07FF, 16'h1FFF, 16'h2000, 16'h3FFF, 16'h4017, 16'h401F};
    case ($urandom_range(0, 6))
      0: return 16'($urandom_range(0, 3) * 16'h0800 +
                    ($urandom_range(0, 1) ? 16'h01F0 : 16'h0000) + $urandom_range(0, 15));
      1: return 16'(16'h2000 + $urandom_range(0, 16'h1FFF));
      2: return 16'(16'h4000 + $urandom_range(0, 31));
      3: return 16'(16'h4020 + $urandom_range(0, 15));
      4: return 16'(16'hFFF0 + $urandom_range(0, 15));
      5: return seams[$urandom_range(0, 5)];
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly bus accesses and balanced push/pull runs on a tracked stack pointer, some noise
  function automatic cmm_pkg::in_beat_t random_item(bit enabled);
    cmm_pkg::in_beat_t b;
    int unsigned       pick;
    pick            = $urandom_range(0, 99);
    b.cmd           = cmm_pkg::CmdRdByte;
    b.address       = pick_address();
    b.write_data    = 16'($urandom);
    b.stack_pointer = stack_top;
    if (pick < 45) begin
      b.cmd = 3'($urandom_range(int'(cmm_pkg::CmdRdByte), int'(cmm_pkg::CmdWrWord)));
    end else if (pick < 88) begin
      if (stack_depth > 200 || (stack_depth > 0 && $urandom_range(0, 1) == 1)) begin
        b.cmd = (stack_depth > 1 && $urandom_range(0, 1) == 1) ?
                cmm_pkg::CmdPullWord : cmm_pkg::CmdPullByte;
      end else begin
        b.cmd = $urandom_range(0, 1) ? cmm_pkg::CmdPushWord : cmm_pkg::CmdPushByte;
      end
      if (enabled) begin
        case (b.cmd)
          cmm_pkg::CmdPushByte: begin stack_top = stack_top - 8'd1; stack_depth += 1; end
          cmm_pkg::CmdPushWord: begin stack_top = stack_top - 8'd2; stack_depth += 2; end
          cmm_pkg::CmdPullByte: begin stack_top = stack_top + 8'd1; stack_depth -= 1; end
          default:              begin stack_top = stack_top + 8'd2; stack_depth -= 2; end
        endcase
      end
    end else begin
      b.cmd           = 3'($urandom);
      b.stack_pointer = 8'($urandom);
    end
    return b;
  endfunction

  function automatic void queue_item(cmm_pkg::cmd_e c, logic [15:0] a, logic [15:0] d,
                                     logic [7:0] sp);
    pending_items.push_back('{cmd: c, address: a, write_data: d, stack_pointer: sp});
  endfunction

  function automatic void queue_random(int count, bit enabled);
    repeat (count) pending_items.push_back(random_item(enabled));
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] exp_val);
    $display("%0t: %s got %h expected %h", $realtime, what, got, exp_val);
    mismatches++;
  endtask

  task automatic write_enable(bit value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    bus_enabled = value;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_valid_i || expected_beats.size() != 0)
      @(posedge clk_i);
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      taken = in_valid_i && !in_stall_o;
      if (taken) begin
        expected_beats.push_back(bus_access(pending_items.pop_front()));
        items_sent++;
        if (!no_idle && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 9);
      end
      if (!in_valid_i || taken) begin
        if (send_gap != 0 || pending_items.size() == 0) begin
          in_valid_i <= 1'b0;
          if (send_gap != 0) send_gap--;
        end else begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_items[0];
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected beat, read_data", out_data_o.read_data, '0);
        end else begin
          want = expected_beats.pop_front();
          if (out_data_o.read_data !== want.read_data)
            report_mismatch("read_data", out_data_o.read_data, want.read_data);
          if (out_data_o.stack_pointer_out !== want.stack_pointer_out)
            report_mismatch("stack_pointer_out", 16'(out_data_o.stack_pointer_out),
                            16'(want.stack_pointer_out));
        end
      end
      if (stall_left != 0) stall_left--;
      else if (!no_idle && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 9);
      out_stall_i <= hold_long || stall_left != 0;
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_long <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_long <= 1'b0;
  end

  initial begin
    #8_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    cmm_pkg::cmd_e c;
    for (int i = 0; i < 65536; i++) bus_bytes[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_enable(1'b0);
    c = c.first();
    repeat (c.num()) begin
      queue_item(c, 16'hFFFF, 16'hFFFF, 8'h00);
      c = c.next();
    end
    drain();

    write_enable(1'b1);
    queue_item(cmm_pkg::CmdWrByte,   16'h0000, 16'h00A5, 8'h00);
    queue_item(cmm_pkg::CmdRdByte,   16'h1800, 16'h0000, 8'hFF);
    queue_item(cmm_pkg::CmdWrWord,   16'h07FF, 16'h1234, 8'h00);
    queue_item(cmm_pkg::CmdRdWord,   16'h1FFF, 16'h0000, 8'h00);
    queue_item(cmm_pkg::CmdWrByte,   16'h3FFF, 16'hFF5A, 8'h00);
    queue_item(cmm_pkg::CmdRdByte,   16'h2007, 16'h0000, 8'h00);
    queue_item(cmm_pkg::CmdWrWord,   16'h4017, 16'hBEEF, 8'h00);
    queue_item(cmm_pkg::CmdRdWord,   16'h4017, 16'h0000, 8'h00);
    queue_item(cmm_pkg::CmdWrWord,   16'h401F, 16'hC3D2, 8'h00);
    queue_item(cmm_pkg::CmdRdWord,   16'h401F, 16'h0000, 8'h00);
    queue_item(cmm_pkg::CmdWrWord,   16'hFFFF, 16'h8001, 8'h00);
    queue_item(cmm_pkg::CmdRdWord,   16'hFFFF, 16'h0000, 8'h00);
    queue_item(cmm_pkg::CmdPushByte, 16'h0000, 16'h0077, 8'h00);
    queue_item(cmm_pkg::CmdPullByte, 16'h0000, 16'h0000, 8'hFF);
    queue_item(cmm_pkg::CmdPushWord, 16'h0000, 16'hCAFE, 8'h00);
    queue_item(cmm_pkg::CmdPullWord, 16'h0000, 16'h0000, 8'hFE);
    queue_item(cmm_pkg::CmdRdByte,   16'h0900, 16'h0000, 8'h00);
    queue_random(700, 1'b1);
    while (items_sent < 250) @(posedge clk_i);
    hold_go = 1'b1;
    drain();

    write_enable(1'b0);
    queue_random(150, 1'b0);
    drain();

    write_enable(1'b1);
    queue_random(600, 1'b1);
    drain();

    no_idle = 1'b1;
    queue_random(475, 1'b1);
    drain();
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

/* files.f */
design/cmm_pkg.sv
design/console_cpu_memory_map.sv
verif/tb.sv
